FILE: design/bfas_pkg.sv
// ----------------------------------------------------------------------------
// bfas_pkg
// Shared widths, defaults and controller/datapath bundles for the
// brute-force assignment search core.
// ----------------------------------------------------------------------------
package bfas_pkg;

    localparam int COST_W        = 16;
    localparam int PERSON_W      = 3;
    localparam int JOB_W         = 3;
    localparam int MIN_COST_W    = 19;
    localparam int SIZE_W        = 4;
    localparam int SIZE_RESET    = 4;
    localparam int MAX_N_DEF     = 8;
    localparam int COST_BITS_DEF = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic init;
        logic swap_rd;
        logic swap_mv;
        logic swap_wr;
        logic push;
        logic pop;
        logic bump;
        logic score_start;
        logic score_issue;
        logic score_update;
        logic emit_start;
        logic emit_next;
        logic finish;
    } bfas_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic load_full;
        logic at_top;
        logic can_descend;
        logic at_root;
        logic cnt_last;
        logic out_free;
    } bfas_status_t;

endpackage

FILE: design/bfas_cost_if.sv
// ----------------------------------------------------------------------------
// bfas_cost_if
// Request channel carrying one cost matrix entry.
// ----------------------------------------------------------------------------
interface bfas_cost_if;
    logic                        valid;
    logic                        ready;
    logic [bfas_pkg::COST_W-1:0] cost;

    modport source (output valid, output cost, input ready);
    modport sink   (input valid, input cost, output ready);
endinterface

FILE: design/bfas_result_if.sv
// ----------------------------------------------------------------------------
// bfas_result_if
// Request channel carrying one per-person assignment result.
// ----------------------------------------------------------------------------
interface bfas_result_if;
    logic                            valid;
    logic                            ready;
    logic [bfas_pkg::PERSON_W-1:0]   person;
    logic [bfas_pkg::JOB_W-1:0]      job;
    logic [bfas_pkg::MIN_COST_W-1:0] min_cost;
    logic                            last;

    modport source (output valid, output person, output job, output min_cost,
                    output last, input ready);
    modport sink   (input valid, input person, input job, input min_cost,
                    input last, output ready);
endinterface

FILE: design/brute_force_assignment_search_core.sv
// Flow: cost requests are taken one per cycle; the request that completes
//   the n-by-n matrix starts the search, which walks all n! permutations,
//   then n results leave one per cycle while the result side is ready.
// Throughput: one run at a time; input stalls from the last cost request
//   until the final result has been loaded into the output register.
// Reset: asynchronous, active low; matrix size returns to 4 and loading restarts.
// ----------------------------------------------------------------------------
// brute_force_assignment_search_core
// Exhaustive assignment search: loads a cost matrix, scores every
// permutation of jobs over persons and reports the cheapest assignment.
// ----------------------------------------------------------------------------
module brute_force_assignment_search_core #(
    parameter int MAX_N     = bfas_pkg::MAX_N_DEF,
    parameter int COST_BITS = bfas_pkg::COST_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bfas_pkg::SIZE_W-1:0] cfg_wr_data,
    bfas_cost_if.sink                   costs,
    bfas_result_if.source               results
);

    bfas_pkg::bfas_cmd_t    cmd;
    bfas_pkg::bfas_status_t status;

    bfas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (costs.valid),
        .in_ready (costs.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bfas_dp #(
        .MAX_N     (MAX_N),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cost         (costs.cost),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_person   (results.person),
        .out_job      (results.job),
        .out_min_cost (results.min_cost),
        .out_last     (results.last)
    );

endmodule

FILE: design/bfas_dp.sv
// ----------------------------------------------------------------------------
// bfas_dp
// Datapath: cost store, permutation and index stack registers, scoring
// accumulator, best-assignment registers and the result output register.
// ----------------------------------------------------------------------------
module bfas_dp #(
    parameter int MAX_N     = bfas_pkg::MAX_N_DEF,
    parameter int COST_BITS = bfas_pkg::COST_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bfas_pkg::SIZE_W-1:0]       cfg_wr_data,
    input  logic [bfas_pkg::COST_W-1:0]       cost,
    input  bfas_pkg::bfas_cmd_t               cmd,
    output bfas_pkg::bfas_status_t            status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bfas_pkg::PERSON_W-1:0]     out_person,
    output logic [bfas_pkg::JOB_W-1:0]        out_job,
    output logic [bfas_pkg::MIN_COST_W-1:0]   out_min_cost,
    output logic                              out_last
);

    localparam int STORE_W  = (COST_BITS < bfas_pkg::COST_W) ? COST_BITS : bfas_pkg::COST_W;
    localparam int DEPTH    = MAX_N * MAX_N;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LC_W     = $clog2(DEPTH + 1);
    localparam int IDX_W    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW       = $clog2(MAX_N + 1);
    localparam int SUM_W    = STORE_W + IDX_W;
    localparam int PERSON_W = bfas_pkg::PERSON_W;
    localparam int JOB_W    = bfas_pkg::JOB_W;
    localparam int MC_W     = bfas_pkg::MIN_COST_W;

    logic [bfas_pkg::SIZE_W-1:0] size_reg;
    logic [LC_W-1:0]             load_count_reg;
    logic [LC_W-1:0]             load_count_next;
    logic [STORE_W-1:0]          cost_mem [DEPTH];
    logic [STORE_W-1:0]          rdata_reg;
    logic                        rd_valid_reg;
    logic [IDX_W-1:0]            perm_reg [MAX_N];
    logic [IDX_W-1:0]            best_perm_reg [MAX_N];
    logic [NW-1:0]               stack_reg [MAX_N];
    logic [IDX_W-1:0]            lvl_reg;
    logic [IDX_W-1:0]            tmp_reg;
    logic [IDX_W-1:0]            cnt_reg;
    logic [ADDR_W-1:0]           row_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            best_sum_reg;
    logic                        first_done_reg;
    logic                        out_valid_reg;
    logic [PERSON_W-1:0]         person_reg;
    logic [JOB_W-1:0]            job_reg;
    logic [MC_W-1:0]             min_cost_reg;
    logic                        last_reg;

    logic [NW-1:0]               n_act;
    logic [IDX_W-1:0]            top;
    logic [LC_W-1:0]             nn;
    logic [NW-1:0]               stack_cur;
    logic [IDX_W-1:0]            sw_b;
    logic [IDX_W-1:0]            perm_addr;
    logic [IDX_W-1:0]            perm_rd;
    logic [ADDR_W-1:0]           rd_addr;

    // Clamp the configured size into 1..MAX_N
    always_comb
    begin
        if (size_reg == '0)
            n_act = NW'(1);
        else if (size_reg > MAX_N)
            n_act = NW'(MAX_N);
        else
            n_act = NW'(size_reg);
    end

    assign top       = IDX_W'(n_act - NW'(1));
    assign nn        = LC_W'({{NW{1'b0}}, n_act} * {{NW{1'b0}}, n_act});
    assign stack_cur = stack_reg[lvl_reg];
    assign sw_b      = IDX_W'(stack_cur);

    always_comb
    begin
        if (load_count_reg < LC_W'(DEPTH))
            load_count_next = load_count_reg + LC_W'(1);
        else
            load_count_next = load_count_reg;
    end

    // Single read port on the permutation registers
    always_comb
    begin
        if (cmd.swap_rd)
            perm_addr = lvl_reg;
        else if (cmd.score_issue)
            perm_addr = cnt_reg;
        else
            perm_addr = sw_b;
    end

    assign perm_rd = perm_reg[perm_addr];
    assign rd_addr = row_reg + ADDR_W'(perm_rd);

    assign status.load_full   = (load_count_next >= nn);
    assign status.at_top      = (lvl_reg == top);
    assign status.can_descend = (stack_cur <= NW'(top));
    assign status.at_root     = (lvl_reg == '0);
    assign status.cnt_last    = (cnt_reg == top);
    assign status.out_free    = !out_valid_reg || out_ready;

    // Cost store: one write port for loading, one registered read port for scoring
    always_ff @(posedge clk)
    begin
        if (cmd.load && (load_count_reg < LC_W'(DEPTH)))
            cost_mem[load_count_reg[ADDR_W-1:0]] <= STORE_W'(cost);
        if (cmd.score_issue)
            rdata_reg <= cost_mem[rd_addr];
    end

    // Control and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= bfas_pkg::SIZE_W'(bfas_pkg::SIZE_RESET);
            load_count_reg <= '0;
            rd_valid_reg   <= 1'b0;
            lvl_reg        <= '0;
            cnt_reg        <= '0;
            row_reg        <= '0;
            best_sum_reg   <= '0;
            first_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < MAX_N; k++)
            begin
                perm_reg[k]      <= IDX_W'(k);
                best_perm_reg[k] <= IDX_W'(k);
                stack_reg[k]     <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                size_reg <= cfg_wr_data;

            if (cmd.finish)
                load_count_reg <= '0;
            else if (cmd.load)
                load_count_reg <= load_count_next;

            if (cmd.init)
            begin
                lvl_reg        <= '0;
                first_done_reg <= 1'b0;
                for (int k = 0; k < MAX_N; k++)
                begin
                    perm_reg[k]  <= IDX_W'(k);
                    stack_reg[k] <= '0;
                end
            end

            // Swap of positions lvl and stack[lvl] in read, move and write steps
            if (cmd.swap_mv)
                perm_reg[lvl_reg] <= perm_rd;
            if (cmd.swap_wr)
                perm_reg[sw_b] <= tmp_reg;

            if (cmd.push)
            begin
                lvl_reg                      <= lvl_reg + IDX_W'(1);
                stack_reg[lvl_reg + IDX_W'(1)] <= NW'(lvl_reg + IDX_W'(1));
            end
            if (cmd.pop)
                lvl_reg <= lvl_reg - IDX_W'(1);
            if (cmd.bump)
                stack_reg[lvl_reg] <= stack_cur + NW'(1);

            rd_valid_reg <= cmd.score_issue;
            if (cmd.score_start || cmd.emit_start)
            begin
                cnt_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.score_issue)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
                row_reg <= row_reg + ADDR_W'(n_act);
            end
            else if (cmd.emit_next)
                cnt_reg <= cnt_reg + IDX_W'(1);

            // Keep the first strictly smallest total
            if (cmd.score_update && (!first_done_reg || (sum_reg < best_sum_reg)))
            begin
                best_sum_reg   <= sum_reg;
                first_done_reg <= 1'b1;
                for (int k = 0; k < MAX_N; k++)
                    best_perm_reg[k] <= perm_reg[k];
            end

            if (cmd.emit_next)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.swap_rd)
            tmp_reg <= perm_rd;

        if (cmd.score_start)
            sum_reg <= '0;
        else if (rd_valid_reg)
            sum_reg <= sum_reg + SUM_W'(rdata_reg);

        if (cmd.emit_next)
        begin
            person_reg   <= PERSON_W'(cnt_reg);
            job_reg      <= JOB_W'(best_perm_reg[cnt_reg]);
            min_cost_reg <= MC_W'(best_sum_reg);
            last_reg     <= (cnt_reg == top);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_person   = person_reg;
    assign out_job      = job_reg;
    assign out_min_cost = min_cost_reg;
    assign out_last     = last_reg;

    a_rd_valid_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.score_issue))
        else $error("cost read data valid without a score issue");

    a_stack_not_below_level: assert property (@(posedge clk) disable iff (!rst_n)
        NW'(lvl_reg) <= stack_cur)
        else $error("index stack entry below its level");

    a_load_within_store: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (load_count_reg < LC_W'(DEPTH)))
        else $error("cost loaded with store already full");

endmodule

FILE: design/bfas_ctrl.sv
// ----------------------------------------------------------------------------
// bfas_ctrl
// Controller: sequences loading, the swap-and-recurse walk over all
// permutations, scoring of each leaf and the emission of results.
// ----------------------------------------------------------------------------
module bfas_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bfas_pkg::bfas_status_t status,
    output bfas_pkg::bfas_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_LOOP,
        S_DSC_MV,
        S_DSC_WR,
        S_SCORE,
        S_DRAIN,
        S_CMP,
        S_RETURN,
        S_ASC_RD,
        S_ASC_MV,
        S_ASC_WR,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.load_full)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (status.at_top)
                begin
                    cmd.score_start = 1'b1;
                    state_next      = S_SCORE;
                end
                else if (status.can_descend)
                begin
                    cmd.swap_rd = 1'b1;
                    state_next  = S_DSC_MV;
                end
                else
                    state_next = S_RETURN;
            end
            S_DSC_MV:
            begin
                cmd.swap_mv = 1'b1;
                state_next  = S_DSC_WR;
            end
            S_DSC_WR:
            begin
                cmd.swap_wr = 1'b1;
                cmd.push    = 1'b1;
                state_next  = S_LOOP;
            end
            S_SCORE:
            begin
                cmd.score_issue = 1'b1;
                if (status.cnt_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_CMP;
            S_CMP:
            begin
                cmd.score_update = 1'b1;
                state_next       = S_RETURN;
            end
            S_RETURN:
            begin
                if (status.at_root)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_ASC_RD;
                end
            end
            S_ASC_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = S_ASC_MV;
            end
            S_ASC_MV:
            begin
                cmd.swap_mv = 1'b1;
                state_next  = S_ASC_WR;
            end
            S_ASC_WR:
            begin
                // swap back, then advance this level's index
                cmd.swap_wr = 1'b1;
                cmd.bump    = 1'b1;
                state_next  = S_LOOP;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_next = 1'b1;
                    if (status.cnt_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    a_swap_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap_wr |-> ($past(cmd.swap_mv) && $past(cmd.swap_rd, 2)))
        else $error("swap write without its read and move cycles");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the brute-force assignment search core. Cost
// requests come from a queue through a clocked driver. A clocked monitor
// compares every result with a local search over all job permutations.
// The bench walks through matrix sizes 1 to 8, out-of-range sizes, a size
// change part way through loading, random gaps on both channels and one
// long hold on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COST_W     = bfas_pkg::COST_W;
    localparam int PERSON_W   = bfas_pkg::PERSON_W;
    localparam int JOB_W      = bfas_pkg::JOB_W;
    localparam int MIN_COST_W = bfas_pkg::MIN_COST_W;
    localparam int SIZE_W     = bfas_pkg::SIZE_W;
    localparam int SIZE_RESET = bfas_pkg::SIZE_RESET;
    localparam int MAX_N_DEF  = bfas_pkg::MAX_N_DEF;

    localparam int STORE_DEPTH   = MAX_N_DEF * MAX_N_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int COST_TARGET   = 460;

    typedef struct packed {
        logic [PERSON_W-1:0]   person;
        logic [JOB_W-1:0]      job;
        logic [MIN_COST_W-1:0] min_cost;
        logic                  last;
    } assignment_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    bfas_cost_if   cost_if();
    bfas_result_if res_if();

    brute_force_assignment_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .costs       (cost_if),
        .results     (res_if)
    );

    always #1 clk = ~clk;

    // Local copy of the matrix store and size register
    logic [COST_W-1:0] cost_mem [STORE_DEPTH];
    int unsigned       fill_count = 0;
    int unsigned       size_reg   = SIZE_RESET;

    assignment_t       expected_assignments [$];
    logic [COST_W-1:0] pending_costs [$];
    assignment_t       want;

    int unsigned       costs_queued    = 0;
    int unsigned       costs_taken     = 0;
    int unsigned       results_checked = 0;
    int unsigned       searches        = 0;
    int unsigned       mismatches      = 0;
    bit [MAX_N_DEF:1]  sizes_searched  = '0;

    bit                gaps_on   = 1'b1;
    bit                hold_req  = 1'b0;
    bit                hold_seen;
    int                hold_left;
    int                gap_left;
    int                stall_left;
    int                stall_next;

    // Try every permutation in swap-and-recurse order; keep the first
    // strictly cheapest one and queue one result per person.
    function automatic void search_cheapest(input int unsigned n);
        int unsigned       top;
        int unsigned       lvl;
        int unsigned       k;
        int unsigned       p;
        int unsigned       lvl_idx [MAX_N_DEF];
        logic [JOB_W-1:0]  order [MAX_N_DEF];
        logic [JOB_W-1:0]  best [MAX_N_DEF];
        logic [JOB_W-1:0]  tmp;
        longint unsigned   total;
        longint unsigned   best_total;
        bit                found;
        assignment_t       a;
        top        = n - 1;
        lvl        = 0;
        found      = 1'b0;
        best_total = 0;
        for (k = 0; k < MAX_N_DEF; k++)
        begin
            order[k]   = JOB_W'(k);
            best[k]    = JOB_W'(k);
            lvl_idx[k] = 0;
        end
        while (1)
        begin
            if (lvl == top)
            begin
                total = 0;
                for (p = 0; p < n; p++)
                    total += cost_mem[(p * n + order[p] % n) % STORE_DEPTH];
                if (!found || total < best_total)
                begin
                    best_total = total;
                    best       = order;
                    found      = 1'b1;
                end
            end
            else if (lvl_idx[lvl] <= top)
            begin
                tmp                   = order[lvl];
                order[lvl]            = order[lvl_idx[lvl]];
                order[lvl_idx[lvl]]   = tmp;
                lvl++;
                lvl_idx[lvl] = lvl;
                continue;
            end
            if (lvl == 0)
                break;
            lvl--;
            tmp                 = order[lvl];
            order[lvl]          = order[lvl_idx[lvl]];
            order[lvl_idx[lvl]] = tmp;
            lvl_idx[lvl]++;
        end
        for (p = 0; p < n; p++)
        begin
            a.person   = PERSON_W'(p);
            a.job      = best[p];
            a.min_cost = best_total[MIN_COST_W-1:0];
            a.last     = (p == n - 1);
            expected_assignments.push_back(a);
        end
        searches++;
        sizes_searched[n] = 1'b1;
    endfunction

    // Store one accepted cost; start a search once the matrix is complete
    function automatic void absorb_cost(input logic [COST_W-1:0] c);
        int unsigned n;
        n = (size_reg == 0) ? 1 : (size_reg > MAX_N_DEF) ? MAX_N_DEF : size_reg;
        if (fill_count < STORE_DEPTH)
        begin
            cost_mem[fill_count] = c;
            fill_count++;
        end
        if (fill_count >= n * n)
        begin
            search_cheapest(n);
            fill_count = 0;
        end
    endfunction

    function automatic void offer_cost(input logic [COST_W-1:0] c);
        pending_costs.push_back(c);
        costs_queued++;
    endfunction

    // Cost request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_if.valid <= 1'b0;
            cost_if.cost  <= '0;
            gap_left      <= 0;
        end
        else
        begin
            if (cost_if.valid && cost_if.ready)
            begin
                absorb_cost(cost_if.cost);
                costs_taken++;
            end
            if (!cost_if.valid || cost_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left      <= gap_left - 1;
                    cost_if.valid <= 1'b0;
                end
                else if (pending_costs.size() != 0)
                begin
                    cost_if.valid <= 1'b1;
                    cost_if.cost  <= pending_costs.pop_front();
                    gap_left      <= gaps_on ? $urandom_range(0, 9) : 0;
                end
                else
                    cost_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_assignments.size() == 0)
                begin
                    $error("unexpected result: person %0d job %0d min_cost %0d last %0d",
                           res_if.person, res_if.job, res_if.min_cost, res_if.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_assignments.pop_front();
                    if (res_if.person !== want.person)
                    begin
                        $error("person: expected %0d, got %0d", want.person, res_if.person);
                        mismatches++;
                    end
                    if (res_if.job !== want.job)
                    begin
                        $error("job: expected %0d, got %0d", want.job, res_if.job);
                        mismatches++;
                    end
                    if (res_if.min_cost !== want.min_cost)
                    begin
                        $error("min_cost: expected %0d, got %0d",
                               want.min_cost, res_if.min_cost);
                        mismatches++;
                    end
                    if (res_if.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, res_if.last);
                        mismatches++;
                    end
                    results_checked++;
                end
                stall_next = gaps_on ? $urandom_range(0, 9) : 0;
            end
            else
                stall_next = (stall_left > 0) ? stall_left - 1 : 0;
            stall_left   <= stall_next;
            res_if.ready <= (stall_next == 0) && (hold_left == 0);
        end
    end

    // One long hold on the result side, so the core backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req && !hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic write_size(input logic [SIZE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        size_reg    = v;
        @(negedge clk);
    endtask

    // Drain all queued requests and expected results, then let the core settle
    task automatic wait_idle();
        while (pending_costs.size() != 0 || cost_if.valid ||
               expected_assignments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_matrix(input int unsigned n);
        int unsigned k;
        int unsigned style;
        style = $urandom_range(0, 3);
        for (k = 0; k < n * n; k++)
        begin
            case (style)
                0:       offer_cost(COST_W'($urandom_range(0, 3)));      // many ties
                1:       offer_cost(16'hFFFF - COST_W'($urandom_range(0, 7)));
                default: offer_cost(COST_W'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    initial
    begin
        int unsigned v;
        int unsigned k;
        int unsigned m;
        int unsigned mats;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default size of 4, all costs at maximum: every permutation ties
        repeat (16) offer_cost(16'hFFFF);
        wait_idle();

        // Size zero acts as one
        write_size(4'd0);
        offer_cost(16'h0000);
        wait_idle();

        // Off-diagonal is cheaper
        write_size(4'd2);
        offer_cost(16'hFFFF);
        offer_cost(16'h0001);
        offer_cost(16'h0002);
        offer_cost(16'hFFFF);
        wait_idle();

        // Shrink the size part way through a load; earlier entries keep place
        write_size(4'd15);
        offer_cost(16'h0005);
        offer_cost(16'h0007);
        offer_cost(16'h0009);
        wait_idle();
        write_size(4'd2);
        offer_cost(16'h0003);
        wait_idle();

        // Largest sizes once each
        write_size(4'd8);
        for (k = 0; k < 64; k++)
            offer_cost(COST_W'($urandom_range(0, 65535)));
        wait_idle();
        write_size(4'd7);
        queue_matrix(7);
        wait_idle();

        // Hold off the result side while more matrices wait at the input
        write_size(4'd2);
        hold_req = 1'b1;
        repeat (3) queue_matrix(2);
        wait_idle();

        while (costs_queued < COST_TARGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
            begin
                write_size(SIZE_W'($urandom_range(4, 6)));
                k = $urandom_range(1, 8);
                repeat (k) offer_cost(COST_W'($urandom_range(0, 65535)));
                wait_idle();
                m = $urandom_range(1, 3);
                write_size(SIZE_W'(m));
                repeat ((m * m > k) ? m * m - k : 1)
                    offer_cost(COST_W'($urandom_range(0, 65535)));
            end
            else
            begin
                v = $urandom_range(0, 6);
                write_size(SIZE_W'(v));
                mats = $urandom_range(1, 3);
                repeat (mats) queue_matrix((v == 0) ? 1 : v);
            end
            wait_idle();
        end
        wait_idle();
        repeat (50) @(negedge clk);

        $display("Checked %0d results from %0d searches over %0d accepted costs.",
                 results_checked, searches, costs_taken);
        $display("Matrix sizes searched (bit n = size n): %b; result hold of %0d cycles.",
                 sizes_searched, HOLD_CYCLES);
        if (mismatches == 0 && expected_assignments.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still expected.", expected_assignments.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: brute_force_assignment_search_core.f
design/bfas_pkg.sv
design/bfas_cost_if.sv
design/bfas_result_if.sv
design/bfas_dp.sv
design/bfas_ctrl.sv
design/brute_force_assignment_search_core.sv
sim/tb_top.sv
